FILE: hw/rtl/amu_pkg.sv
// Package: shared types, constants and mnemonic tables of the mnemonic unescaper.
`default_nettype none
package amu_pkg;

  localparam int unsigned HOLD_DEPTH = 5;
  localparam int unsigned CNT_W      = 3;
  localparam int unsigned NAME_COUNT = 34;
  localparam int unsigned MASK_W     = NAME_COUNT + 1;
  localparam int unsigned HEX_BIT    = NAME_COUNT;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [7:0] CHR_LT   = 8'h3C;
  localparam logic [7:0] CHR_GT   = 8'h3E;
  localparam logic [7:0] CHR_ZERO = 8'h30;
  localparam logic [7:0] CHR_X    = 8'h78;

  // three-letter text per name; two-letter names are padded with a space
  localparam logic [23:0] NAME_TXT [NAME_COUNT] = '{
    "NUL", "SOH", "STX", "ETX", "EOT", "ENQ", "ACK", "BEL",
    "BS ", "HT ", "LF ", "VT ", "FF ", "CR ", "SO ", "SI ",
    "DLE", "DC1", "DC2", "DC3", "DC4", "NAK", "SYN", "ETB",
    "CAN", "EM ", "SUB", "ESC", "FS ", "GS ", "RS ", "US ",
    "SP ", "DEL"
  };

  localparam logic [1:0] NAME_LEN [NAME_COUNT] = '{
    2'd3, 2'd3, 2'd3, 2'd3, 2'd3, 2'd3, 2'd3, 2'd3,
    2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2,
    2'd3, 2'd3, 2'd3, 2'd3, 2'd3, 2'd3, 2'd3, 2'd3,
    2'd3, 2'd2, 2'd3, 2'd3, 2'd2, 2'd2, 2'd2, 2'd2,
    2'd2, 2'd3
  };

  localparam logic [7:0] NAME_VAL [NAME_COUNT] = '{
    8'd0,  8'd1,  8'd2,  8'd3,  8'd4,  8'd5,  8'd6,  8'd7,
    8'd8,  8'd9,  8'd10, 8'd11, 8'd12, 8'd13, 8'd14, 8'd15,
    8'd16, 8'd17, 8'd18, 8'd19, 8'd20, 8'd21, 8'd22, 8'd23,
    8'd24, 8'd25, 8'd26, 8'd27, 8'd28, 8'd29, 8'd30, 8'd31,
    8'd32, 8'h7F
  };

  // one queue entry: held bytes to flush literally, then an optional tail byte
  typedef struct packed {
    logic [CNT_W-1:0]                 cnt;
    logic [HOLD_DEPTH-1:0][7:0]       chars;
    logic                             tail_vld;
    logic [7:0]                       tail;
  } entry_t;

endpackage
`default_nettype wire

FILE: hw/rtl/ascii_mnemonic_unescaper_top.sv
// Mnemonic unescaper top level: front end, command queue and byte emitter.
// A character is taken every cycle while the two-entry command queue has room.
// Each character that yields output becomes one command; the emitter sends one
// byte per cycle while the receiver is ready, so a command of k bytes (1 to 6) holds it until all k are sent.
// Plain text and completed mnemonics thus run at one character per cycle while the output is ready; a
// literal flush of held characters stalls the input once the queue fills.
`default_nettype none
module ascii_mnemonic_unescaper_top (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] text_char_i,
  input  wire logic       end_of_text_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [7:0]      out_byte_o,
  output logic            last_of_run_o
);

  logic            push;
  logic            push_ready;
  amu_pkg::entry_t push_data;
  logic            cmd_valid;
  amu_pkg::entry_t cmd;
  logic            cmd_pop;

  amu_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .text_char_i   (text_char_i),
    .end_of_text_i (end_of_text_i),
    .push_o        (push),
    .push_data_o   (push_data),
    .push_ready_i  (push_ready)
  );

  amu_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_data_i  (push_data),
    .push_ready_o (push_ready),
    .pop_valid_o  (cmd_valid),
    .pop_data_o   (cmd),
    .pop_i        (cmd_pop)
  );

  amu_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_valid_i   (cmd_valid),
    .cmd_i         (cmd),
    .cmd_pop_o     (cmd_pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_byte_o    (out_byte_o),
    .last_of_run_o (last_of_run_o)
  );

endmodule
`default_nettype wire

FILE: hw/rtl/amu_front.sv
// Front end: holds partial mnemonics, tracks candidate names, issues emit commands.
`default_nettype none
module amu_front (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire logic [7:0]      text_char_i,
  input  wire logic            end_of_text_i,
  output logic                 push_o,
  output amu_pkg::entry_t      push_data_o,
  input  wire logic            push_ready_i
);

  logic [amu_pkg::HOLD_DEPTH-1:0][7:0] held_q, held_d;
  logic [amu_pkg::CNT_W-1:0]           cnt_q, cnt_d;
  logic [amu_pkg::MASK_W-1:0]          mask_q, mask_d;

  logic [amu_pkg::MASK_W-1:0] match;
  logic [amu_pkg::MASK_W-1:0] done_v;
  logic [amu_pkg::MASK_W-1:0] pre_v;
  logic                       done;
  logic                       pre;
  logic [7:0]                 done_val;
  logic [7:0]                 hex_val;
  logic [4:0]                 hi_dig;
  logic [4:0]                 lo_dig;
  logic                       accept;
  amu_pkg::entry_t            ent;

  function automatic logic [7:0] name_chr(input logic [23:0] txt,
                                          input logic [amu_pkg::CNT_W-1:0] pos);
    logic [7:0] r;
    case (pos)
      3'd1:    r = txt[23:16];
      3'd2:    r = txt[15:8];
      3'd3:    r = txt[7:0];
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [4:0] hex_dig(input logic [7:0] ch);
    logic [4:0] r;
    r = 5'h10;
    if (ch >= 8'h30 && ch <= 8'h39) begin
      r = {1'b0, 4'(ch - 8'h30)};
    end else if (ch >= 8'h41 && ch <= 8'h46) begin
      r = {1'b0, 4'(ch - 8'h37)};
    end
    return r;
  endfunction

  assign accept     = in_valid_i && push_ready_i;
  assign in_ready_o = push_ready_i;

  always_comb begin
    logic [amu_pkg::CNT_W-1:0] close_pos;
    logic [7:0]                want;
    logic [4:0]                hd;
    for (int i = 0; i < amu_pkg::NAME_COUNT; i++) begin
      close_pos = {1'b0, amu_pkg::NAME_LEN[i]} + 3'd1;
      want = (cnt_q == close_pos) ? amu_pkg::CHR_GT
                                  : name_chr(amu_pkg::NAME_TXT[i], cnt_q);
      match[i]  = mask_q[i] && (cnt_q <= close_pos) && (text_char_i == want);
      done_v[i] = match[i] && (cnt_q == close_pos);
      pre_v[i]  = match[i] && (cnt_q < close_pos);
    end
    hd = hex_dig(text_char_i);
    case (cnt_q)
      3'd1:    match[amu_pkg::HEX_BIT] = text_char_i == amu_pkg::CHR_ZERO;
      3'd2:    match[amu_pkg::HEX_BIT] = text_char_i == amu_pkg::CHR_X;
      3'd3:    match[amu_pkg::HEX_BIT] = !hd[4] && hd[3];
      3'd4:    match[amu_pkg::HEX_BIT] = !hd[4];
      3'd5:    match[amu_pkg::HEX_BIT] = text_char_i == amu_pkg::CHR_GT;
      default: match[amu_pkg::HEX_BIT] = 1'b0;
    endcase
    match[amu_pkg::HEX_BIT]  = match[amu_pkg::HEX_BIT] && mask_q[amu_pkg::HEX_BIT];
    done_v[amu_pkg::HEX_BIT] = match[amu_pkg::HEX_BIT] && (cnt_q == 3'd5);
    pre_v[amu_pkg::HEX_BIT]  = match[amu_pkg::HEX_BIT] && (cnt_q < 3'd5);
  end

  assign hi_dig  = hex_dig(held_q[3]);
  assign lo_dig  = hex_dig(held_q[4]);
  assign hex_val = {hi_dig[3:0], lo_dig[3:0]};

  always_comb begin
    done_val = 8'h00;
    for (int i = 0; i < amu_pkg::NAME_COUNT; i++) begin
      if (done_v[i]) begin
        done_val = done_val | amu_pkg::NAME_VAL[i];
      end
    end
    if (done_v[amu_pkg::HEX_BIT]) begin
      done_val = done_val | hex_val;
    end
  end

  assign done = |done_v;
  assign pre  = |pre_v;

  always_comb begin
    held_d       = held_q;
    cnt_d        = cnt_q;
    mask_d       = mask_q;
    ent.cnt      = '0;
    ent.chars    = held_q;
    ent.tail_vld = 1'b0;
    ent.tail     = text_char_i;
    if (cnt_q == '0) begin
      if (text_char_i == amu_pkg::CHR_LT) begin
        if (end_of_text_i) begin
          ent.tail_vld = 1'b1;
        end else begin
          held_d[0] = text_char_i;
          cnt_d     = 3'd1;
          mask_d    = '1;
        end
      end else begin
        ent.tail_vld = 1'b1;
      end
    end else if (done) begin
      ent.tail_vld = 1'b1;
      ent.tail     = done_val;
      cnt_d        = '0;
    end else if (pre && cnt_q < amu_pkg::CNT_W'(amu_pkg::HOLD_DEPTH)) begin
      if (end_of_text_i) begin
        ent.cnt      = cnt_q;
        ent.tail_vld = 1'b1;
        cnt_d        = '0;
      end else begin
        held_d[cnt_q] = text_char_i;
        cnt_d         = cnt_q + 3'd1;
        mask_d        = match;
      end
    end else begin
      ent.cnt = cnt_q;
      if (text_char_i == amu_pkg::CHR_LT && !end_of_text_i) begin
        held_d[0] = text_char_i;
        cnt_d     = 3'd1;
        mask_d    = '1;
      end else begin
        ent.tail_vld = 1'b1;
        cnt_d        = '0;
      end
    end
  end

  assign push_o      = accept && (ent.cnt != '0 || ent.tail_vld);
  assign push_data_o = ent;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      mask_q <= '0;
    end else if (accept) begin
      cnt_q  <= cnt_d;
      mask_q <= mask_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      held_q <= held_d;
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/amu_queue.sv
// Command queue: small register FIFO between front end and emitter.
`default_nettype none
module amu_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire amu_pkg::entry_t push_data_i,
  output logic                 push_ready_o,
  output logic                 pop_valid_o,
  output amu_pkg::entry_t      pop_data_o,
  input  wire logic            pop_i
);

  localparam int unsigned PTR_W = $clog2(amu_pkg::QUEUE_DEPTH);

  amu_pkg::entry_t mem_q [amu_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_q, wr_d;
  logic [PTR_W-1:0] rd_q, rd_d;
  logic [PTR_W:0]   fill_q, fill_d;
  logic             do_push;
  logic             do_pop;

  assign push_ready_o = fill_q != (PTR_W+1)'(amu_pkg::QUEUE_DEPTH);
  assign pop_valid_o  = fill_q != '0;
  assign pop_data_o   = mem_q[rd_q];
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;

  always_comb begin
    wr_d   = wr_q;
    rd_d   = rd_q;
    fill_d = fill_q;
    if (do_push) begin
      wr_d = (wr_q == PTR_W'(amu_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == PTR_W'(amu_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      fill_d = fill_q + 1'b1;
    end else if (do_pop && !do_push) begin
      fill_d = fill_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= '0;
      rd_q   <= '0;
      fill_q <= '0;
    end else begin
      wr_q   <= wr_d;
      rd_q   <= rd_d;
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/amu_back.sv
// Emitter: steps through one command per run, one byte per transfer, into an output register.
`default_nettype none
module amu_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            cmd_valid_i,
  input  wire amu_pkg::entry_t cmd_i,
  output logic                 cmd_pop_o,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output logic [7:0]           out_byte_o,
  output logic                 last_of_run_o
);

  logic [amu_pkg::CNT_W-1:0] idx_q, idx_d;
  logic                      ov_q;
  logic [7:0]                byte_q, byte_d;
  logic                      last_q, last_d;
  logic                      slot_free;
  logic                      step;

  assign slot_free = !ov_q || out_ready_i;
  assign step      = slot_free && cmd_valid_i;

  always_comb begin
    if (idx_q < cmd_i.cnt) begin
      byte_d = cmd_i.chars[idx_q];
      last_d = (idx_q + 3'd1 == cmd_i.cnt) && !cmd_i.tail_vld;
    end else begin
      byte_d = cmd_i.tail;
      last_d = 1'b1;
    end
    idx_d = last_d ? '0 : idx_q + 3'd1;
  end

  assign cmd_pop_o = step && last_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      ov_q  <= 1'b0;
    end else begin
      if (step) begin
        idx_q <= idx_d;
      end
      if (slot_free) begin
        ov_q <= cmd_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      byte_q <= byte_d;
      last_q <= last_d;
    end
  end

  assign out_valid_o   = ov_q;
  assign out_byte_o    = byte_q;
  assign last_of_run_o = last_q;

endmodule
`default_nettype wire

FILE: sim/ascii_mnemonic_unescaper_checker.sv
// Checker: predicts unescaped output bytes from input transfers and compares them.
`default_nettype none
module ascii_mnemonic_unescaper_checker (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  input  wire logic       in_ready_i,
  input  wire logic [7:0] text_char_i,
  input  wire logic       end_of_text_i,
  input  wire logic       out_valid_i,
  input  wire logic       out_ready_i,
  input  wire logic [7:0] out_byte_i,
  input  wire logic       last_of_run_i,
  output int              pending_o,
  output int              fail_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NO_MATCH = -1;
  localparam int PARTIAL  = -2;
  localparam int SEQ_MAX  = 6;

  typedef struct packed {
    logic [7:0] value;
    logic       last;
  } out_byte_t;

  string ctrl_name [34] = '{
    "NUL", "SOH", "STX", "ETX", "EOT", "ENQ", "ACK", "BEL",
    "BS", "HT", "LF", "VT", "FF", "CR", "SO", "SI",
    "DLE", "DC1", "DC2", "DC3", "DC4", "NAK", "SYN", "ETB",
    "CAN", "EM", "SUB", "ESC", "FS", "GS", "RS", "US",
    "SP", "DEL"
  };

  out_byte_t  expected_bytes [$];
  logic [7:0] pending_chars [amu_pkg::HOLD_DEPTH];
  int         pending_len;
  int         fails;

  assign pending_o    = expected_bytes.size();
  assign fail_count_o = fails;

  function automatic int hex_digit(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
    if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h41 + 10;
    return -1;
  endfunction

  // byte value of a complete mnemonic, PARTIAL for a proper prefix, else NO_MATCH
  function automatic int match_mnemonic(input logic [7:0] seq [SEQ_MAX], input int n);
    int  full;
    bit  ok;
    bit  prefix;
    byte want;
    prefix = 0;
    if (n < 1 || n > SEQ_MAX || seq[0] != amu_pkg::CHR_LT) return NO_MATCH;
    for (int i = 0; i < 34; i++) begin
      full = ctrl_name[i].len() + 2;
      if (n > full) continue;
      ok = 1;
      for (int k = 1; k < n; k++) begin
        want = (k == full - 1) ? byte'(amu_pkg::CHR_GT) : ctrl_name[i][k-1];
        if (seq[k] != 8'(want)) ok = 0;
      end
      if (ok) begin
        if (n == full) return (i < 33) ? i : 'h7F;
        prefix = 1;
      end
    end
    ok = 1;
    for (int k = 1; k < n; k++) begin
      case (k)
        1: if (seq[k] != amu_pkg::CHR_ZERO) ok = 0;
        2: if (seq[k] != amu_pkg::CHR_X) ok = 0;
        3: if (hex_digit(seq[k]) < 8) ok = 0;
        4: if (hex_digit(seq[k]) < 0) ok = 0;
        default: if (seq[k] != amu_pkg::CHR_GT) ok = 0;
      endcase
    end
    if (ok) begin
      if (n == SEQ_MAX) return hex_digit(seq[3]) * 16 + hex_digit(seq[4]);
      prefix = 1;
    end
    return prefix ? PARTIAL : NO_MATCH;
  endfunction

  task automatic unescape_char(input logic [7:0] c, input logic eot);
    logic [7:0] emitted [$];
    logic [7:0] seq [SEQ_MAX];
    int         n;
    int         r;
    out_byte_t  item;
    n = pending_len;
    if (n == 0) begin
      if (c == amu_pkg::CHR_LT) begin
        pending_chars[0] = c;
        pending_len = 1;
      end else begin
        emitted.push_back(c);
      end
    end else begin
      for (int i = 0; i < SEQ_MAX; i++) seq[i] = '0;
      for (int i = 0; i < n; i++) seq[i] = pending_chars[i];
      seq[n] = c;
      r = match_mnemonic(seq, n + 1);
      if (r >= 0) begin
        emitted.push_back(8'(r));
        pending_len = 0;
      end else if (r == PARTIAL && n < amu_pkg::HOLD_DEPTH) begin
        pending_chars[n] = c;
        pending_len = n + 1;
      end else begin
        for (int i = 0; i < n; i++) emitted.push_back(pending_chars[i]);
        pending_len = 0;
        if (c == amu_pkg::CHR_LT) begin
          pending_chars[0] = c;
          pending_len = 1;
        end else begin
          emitted.push_back(c);
        end
      end
    end
    if (eot) begin
      for (int i = 0; i < pending_len; i++) emitted.push_back(pending_chars[i]);
      pending_len = 0;
    end
    foreach (emitted[i]) begin
      item.value = emitted[i];
      item.last  = (i == emitted.size() - 1);
      expected_bytes.push_back(item);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_byte_t exp_item;
    if (!rst_ni) begin
      pending_len = 0;
      expected_bytes.delete();
      fails = 0;
    end else begin
      if (in_valid_i && in_ready_i) unescape_char(text_char_i, end_of_text_i);
      if (out_valid_i && out_ready_i) begin
        if (expected_bytes.size() == 0) begin
          $error("unexpected transfer: out_byte %0h last_of_run %0b",
                 out_byte_i, last_of_run_i);
          fails++;
        end else begin
          exp_item = expected_bytes.pop_front();
          if (out_byte_i !== exp_item.value) begin
            $error("out_byte: expected %0h, actual %0h", exp_item.value, out_byte_i);
            fails++;
          end
          if (last_of_run_i !== exp_item.last) begin
            $error("last_of_run: expected %0b, actual %0b", exp_item.last, last_of_run_i);
            fails++;
          end
        end
      end
    end
  end

endmodule
`default_nettype wire

FILE: sim/ascii_mnemonic_unescaper_top_tb.sv
// Testbench top: drives text and mnemonic streams into the unescaper and reports the verdict.
`default_nettype none
module ascii_mnemonic_unescaper_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int         RANDOM_ITEMS = 500;
  localparam int         HEX_INDEX    = amu_pkg::NAME_COUNT;
  localparam logic [7:0] CHR_A        = 8'h41;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_ready_o;
  logic [7:0] text_char_i;
  logic       end_of_text_i;
  logic       out_valid_o;
  logic       out_ready_i;
  logic [7:0] out_byte_o;
  logic       last_of_run_o;

  int         pending_count;
  int         fail_count;
  int         sent_count;
  int         burst_left;
  logic [7:0] text_buf [$];

  ascii_mnemonic_unescaper_top u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .text_char_i   (text_char_i),
    .end_of_text_i (end_of_text_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_byte_o    (out_byte_o),
    .last_of_run_o (last_of_run_o)
  );

  ascii_mnemonic_unescaper_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_i    (in_ready_o),
    .text_char_i   (text_char_i),
    .end_of_text_i (end_of_text_i),
    .out_valid_i   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_byte_i    (out_byte_o),
    .last_of_run_i (last_of_run_o),
    .pending_o     (pending_count),
    .fail_count_o  (fail_count)
  );

  initial clk_i = 1'b0;
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("ascii_mnemonic_unescaper_top_tb failed");
    $finish;
  end

  // receiver backpressure in modes that are drawn anew after each random-length phase
  initial begin
    int ready_phase;
    int ready_mode;
    ready_phase = 0;
    ready_mode  = 0;
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (ready_phase == 0) begin
        ready_mode  = $urandom_range(0, 3);
        ready_phase = $urandom_range(16, 96);
      end
      ready_phase--;
      case (ready_mode)
        0: out_ready_i <= 1'b1;
        1: out_ready_i <= 1'($urandom_range(0, 1));
        2: out_ready_i <= ($urandom_range(0, 3) == 0);
        default: out_ready_i <= ~out_ready_i;
      endcase
    end
  end

  task automatic send_char(input logic [7:0] c, input logic eot);
    in_valid_i    <= 1'b1;
    text_char_i   <= c;
    end_of_text_i <= eot;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sent_count++;
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 3) != 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
    end
  endtask

  task automatic send_text(input logic eot_at_end);
    foreach (text_buf[i])
      send_char(text_buf[i], eot_at_end && (i == text_buf.size() - 1));
    text_buf.delete();
  endtask

  function automatic logic [7:0] hex_char(input int d);
    return (d < 10) ? amu_pkg::CHR_ZERO + 8'(d) : CHR_A + 8'(d - 10);
  endfunction

  // appends a complete mnemonic: a named one, or the hex form for HEX_INDEX
  task automatic add_mnemonic(input int idx, input int code);
    text_buf.push_back(amu_pkg::CHR_LT);
    if (idx == HEX_INDEX) begin
      text_buf.push_back(amu_pkg::CHR_ZERO);
      text_buf.push_back(amu_pkg::CHR_X);
      text_buf.push_back(hex_char(code / 16));
      text_buf.push_back(hex_char(code % 16));
    end else begin
      for (int k = 0; k < int'(amu_pkg::NAME_LEN[idx]); k++)
        text_buf.push_back(amu_pkg::NAME_TXT[idx][23 - 8*k -: 8]);
    end
    text_buf.push_back(amu_pkg::CHR_GT);
  endtask

  initial begin
    int kind;
    int cut;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    text_char_i   = '0;
    end_of_text_i = 1'b0;
    sent_count    = 0;
    burst_left    = $urandom_range(1, 24);
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: field extremes, zero character, both ends of hex range
    send_char(8'hFF, 1'b0);
    send_char(8'h00, 1'b0);
    send_char(8'h01, 1'b0);
    add_mnemonic(0, 0);
    send_text(1'b0);
    add_mnemonic(HEX_INDEX, 'hFF);
    send_text(1'b0);
    add_mnemonic(HEX_INDEX, 'h80);
    send_text(1'b0);
    // lowercase hex digit breaks the match
    text_buf = '{amu_pkg::CHR_LT, amu_pkg::CHR_ZERO, amu_pkg::CHR_X, 8'h61};
    send_text(1'b1);
    // second bracket inside a match restarts it
    text_buf.push_back(amu_pkg::CHR_LT);
    add_mnemonic(32, 0);
    send_text(1'b0);
    // partial mnemonic flushed at end of text
    text_buf = '{amu_pkg::CHR_LT, 8'h44, 8'h45};
    send_text(1'b1);
    // end of text with nothing held
    send_char(CHR_A, 1'b1);

    while (sent_count < RANDOM_ITEMS) begin
      kind = $urandom_range(0, 99);
      if (kind < 50) begin
        add_mnemonic($urandom_range(0, HEX_INDEX), $urandom_range('h80, 'hFF));
      end else if (kind < 72) begin
        add_mnemonic($urandom_range(0, HEX_INDEX), $urandom_range('h80, 'hFF));
        cut = $urandom_range(1, text_buf.size() - 1);
        while (text_buf.size() > cut) void'(text_buf.pop_back());
        if ($urandom_range(0, 3) == 0) text_buf.push_back(amu_pkg::CHR_LT);
        else text_buf.push_back(8'($urandom_range(0, 255)));
      end else begin
        repeat ($urandom_range(1, 8)) begin
          if ($urandom_range(0, 19) == 0) text_buf.push_back(8'h00);
          else text_buf.push_back(8'($urandom_range(1, 255)));
        end
      end
      send_text($urandom_range(0, 7) == 0);
    end
    in_valid_i <= 1'b0;
    @(posedge clk_i);

    while (pending_count != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("ascii_mnemonic_unescaper_top_tb passed");
    end else begin
      $display("ascii_mnemonic_unescaper_top_tb failed");
    end
    $finish;
  end

endmodule
`default_nettype wire

FILE: filelist.f
hw/rtl/amu_pkg.sv
hw/rtl/amu_front.sv
hw/rtl/amu_queue.sv
hw/rtl/amu_back.sv
hw/rtl/ascii_mnemonic_unescaper_top.sv
sim/ascii_mnemonic_unescaper_checker.sv
sim/ascii_mnemonic_unescaper_top_tb.sv
